// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// Each macro takes a label, a clock, a reset, a trigger and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the trigger.
`define ASSERT_IMPLY(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("assertion failed");

// The consequence must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/tstat_pkg.sv -----
// ----------------------------------------------------------------------------
// tstat_pkg
// Types and constants shared by the timer statistics table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tstat_pkg;

  localparam int INDEX_W  = 6;
  localparam int SAMPLE_W = 24;
  localparam int COUNT_W  = 32;
  localparam int TOTAL_W  = 56;
  localparam int VAR_W    = 64;

  // Divider: dividend, divisor and step counter widths.
  localparam int DIV_NW = 72;
  localparam int DIV_DW = 33;
  localparam int DIV_CW = 7;
  localparam logic [DIV_CW-1:0] MEAN_STEPS = 7'd72;
  localparam logic [DIV_CW-1:0] WORD_STEPS = 7'd64;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [TOTAL_W-1:0]  total;
    logic [SAMPLE_W-1:0] minimum;
    logic [SAMPLE_W-1:0] maximum;
    logic [VAR_W-1:0]    variance;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    count: '0, total: '0, minimum: '1, maximum: '0, variance: '0};

  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_T2   = 2'd1,
    DIV_VAR  = 2'd2
  } div_sel_t;

  typedef enum logic [1:0] {
    SQ_P0 = 2'd0,
    SQ_P1 = 2'd1,
    SQ_P2 = 2'd2,
    SQ_P3 = 2'd3
  } sq_phase_t;

  typedef struct packed {
    logic      clear_wr;
    logic      take;
    logic      reduce_step;
    logic      rd_en;
    logic      load_entry;
    logic      div_start;
    div_sel_t  div_sel;
    logic      sq_step;
    sq_phase_t sq_phase;
    logic      write_entry;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic idx_high;
    logic count_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/tstat_in_if.sv -----
// ----------------------------------------------------------------------------
// tstat_in_if
// Sample channel: one timer index and one duration per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tstat_in_if;
  logic                              valid;
  logic                              ready;
  logic [tstat_pkg::INDEX_W-1:0]     timer_index;
  logic [tstat_pkg::SAMPLE_W-1:0]    sample_ticks;

  modport source (output valid, timer_index, sample_ticks, input ready);
  modport sink   (input valid, timer_index, sample_ticks, output ready);
endinterface

`default_nettype wire

// ----- hdl/tstat_out_if.sv -----
// ----------------------------------------------------------------------------
// tstat_out_if
// Result channel: the updated statistics of one entry per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tstat_out_if;
  logic                              valid;
  logic                              ready;
  logic [tstat_pkg::INDEX_W-1:0]     entry_index;
  logic [tstat_pkg::COUNT_W-1:0]     sample_count;
  logic [tstat_pkg::TOTAL_W-1:0]     total_ticks;
  logic [tstat_pkg::SAMPLE_W-1:0]    minimum_ticks;
  logic [tstat_pkg::SAMPLE_W-1:0]    maximum_ticks;
  logic [tstat_pkg::VAR_W-1:0]       variance_fixed;

  modport source (output valid, entry_index, sample_count, total_ticks,
                  minimum_ticks, maximum_ticks, variance_fixed, input ready);
  modport sink   (input valid, entry_index, sample_count, total_ticks,
                  minimum_ticks, maximum_ticks, variance_fixed, output ready);
endinterface

`default_nettype wire

// ----- hdl/timer_statistics_table_core.sv -----
// ----------------------------------------------------------------------------
// timer_statistics_table_core
// Per-timer count, total, minimum, maximum and running sample variance.
// ----------------------------------------------------------------------------
// Usage. Each transfer on the samples channel names a timer entry and gives
// one duration in ticks. The entry is updated and its new statistics leave
// as one transfer on the results channel. An index at or beyond NUM_TIMERS
// is folded back into the table by repeated subtraction of NUM_TIMERS.
// Sequence. One sample is worked on at a time. The first sample of an entry
// goes from the table read straight to write back. Every later sample runs
// a 72-step division for the mean, a squaring pass in phases SQ_P0 to SQ_P3
// on one 24x24 multiplier, and two 64-step divisions for the variance terms,
// all on a single shared bit-serial divider, between the table read and the
// write back. An index is folded one subtraction at a time before the read.
// Reset. A synchronous reset starts a clearing pass that writes the reset
// entry into each of the NUM_TIMERS rows, one row per cycle; samples are
// refused until it ends.
// Stalls. The result sits in an output register. While the receiver stalls,
// the next sample is still taken and computed; only its write back waits
// until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_statistics_table_core #(
  parameter int NUM_TIMERS  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  tstat_in_if.sink    samples,
  tstat_out_if.source results
);

  tstat_pkg::cmd_t    cmd;
  tstat_pkg::status_t status;
  tstat_pkg::entry_t  out_entry;
  logic               in_ready;

  // The controller owns the sample handshake.
  tstat_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(samples.valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  assign samples.ready = in_ready;

  // The datapath holds the table, the arithmetic and the result register.
  tstat_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_index (samples.timer_index),
    .in_sample(samples.sample_ticks),
    .out_ready(results.ready),
    .out_valid(results.valid),
    .out_index(results.entry_index),
    .out_entry(out_entry)
  );

  assign results.sample_count   = out_entry.count;
  assign results.total_ticks    = out_entry.total;
  assign results.minimum_ticks  = out_entry.minimum;
  assign results.maximum_ticks  = out_entry.maximum;
  assign results.variance_fixed = out_entry.variance;

endmodule

`default_nettype wire

// ----- hdl/tstat_ram.sv -----
// ----------------------------------------------------------------------------
// tstat_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tstat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tstat_div.sv -----
// ----------------------------------------------------------------------------
// tstat_div
// Restoring divider, one quotient bit per cycle, dividend left aligned.
// ----------------------------------------------------------------------------
`default_nettype none

module tstat_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [tstat_pkg::DIV_NW-1:0]    dividend,
  input  logic [tstat_pkg::DIV_DW-1:0]    divisor,
  input  logic [tstat_pkg::DIV_CW-1:0]    steps,
  output logic [tstat_pkg::DIV_NW-1:0]    quotient,
  output logic [tstat_pkg::DIV_DW-1:0]    remainder,
  output logic                            done
);

  logic [tstat_pkg::DIV_DW-1:0] rem;
  logic [tstat_pkg::DIV_NW-1:0] quo;
  logic [tstat_pkg::DIV_DW-1:0] dvs;
  logic [tstat_pkg::DIV_CW-1:0] cnt;
  logic                         busy;
  logic [tstat_pkg::DIV_DW:0]   trial;
  logic                         fits;

  // The shifted-in partial remainder stays below twice the divisor.
  assign trial = {rem, quo[tstat_pkg::DIV_NW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= steps;
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
        rem <= fits ? tstat_pkg::DIV_DW'(trial - {1'b0, dvs})
                    : trial[tstat_pkg::DIV_DW-1:0];
        quo <= {quo[tstat_pkg::DIV_NW-2:0], fits};
      end
    end
  end

  assign done      = busy && (cnt == '0);
  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

// ----- hdl/tstat_dp.sv -----
// ----------------------------------------------------------------------------
// tstat_dp
// Datapath: entry store, divider, squaring unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tstat_dp #(
  parameter int NUM_TIMERS  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tstat_pkg::cmd_t                   cmd,
  output tstat_pkg::status_t                status,
  input  logic [tstat_pkg::INDEX_W-1:0]     in_index,
  input  logic [tstat_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [tstat_pkg::INDEX_W-1:0]     out_index,
  output tstat_pkg::entry_t                 out_entry
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int IW = ((AW > tstat_pkg::INDEX_W) ? AW : tstat_pkg::INDEX_W) + 1;
  localparam logic [tstat_pkg::SAMPLE_W-1:0] XMASK =
    tstat_pkg::SAMPLE_W'((25'(1) << SAMPLE_BITS) - 25'(1));
  localparam logic [IW-1:0] NT = IW'(NUM_TIMERS);

  logic [IW-1:0]                  idx;
  logic [tstat_pkg::SAMPLE_W-1:0] x;
  tstat_pkg::entry_t              ent;
  tstat_pkg::entry_t              rdata;
  tstat_pkg::entry_t              new_ent;
  tstat_pkg::entry_t              wdata;
  logic [AW-1:0]                  clr_addr;
  logic [AW-1:0]                  addr;
  tstat_pkg::div_sel_t            sel_q;
  logic [55:0]                    d;
  logic                           big;
  logic [47:0]                    prod;
  logic [23:0]                    mul_a;
  logic [23:0]                    mul_b;
  logic [63:0]                    sq;
  logic [64:0]                    sq_sum;
  logic [63:0]                    t2;
  logic [63:0]                    vnew;

  logic [tstat_pkg::DIV_NW-1:0]   div_n;
  logic [tstat_pkg::DIV_DW-1:0]   div_d;
  logic [tstat_pkg::DIV_CW-1:0]   div_steps;
  logic [tstat_pkg::DIV_NW-1:0]   quo;
  logic [tstat_pkg::DIV_DW-1:0]   rem;
  logic                           div_done;

  logic [55:0]                    mean;
  logic [55:0]                    xf;
  logic [63:0]                    t1;
  logic [64:0]                    vsum;
  logic [56:0]                    tsum;

  assign addr = cmd.clear_wr ? clr_addr : idx[AW-1:0];

  tstat_ram #(
    .WIDTH($bits(tstat_pkg::entry_t)),
    .DEPTH(NUM_TIMERS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.clear_wr || cmd.write_entry),
    .waddr(addr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(addr),
    .rdata(rdata)
  );

  assign wdata = cmd.clear_wr ? tstat_pkg::ENTRY_RESET : new_ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Divider operands for the three divisions of one update.
  always_comb begin
    case (cmd.div_sel)
      tstat_pkg::DIV_T2: begin
        div_n     = {sq, 8'b0};
        div_d     = {1'b0, ent.count} + 33'd1;
        div_steps = tstat_pkg::WORD_STEPS;
      end
      tstat_pkg::DIV_VAR: begin
        div_n     = {ent.variance, 8'b0};
        div_d     = {1'b0, ent.count};
        div_steps = tstat_pkg::WORD_STEPS;
      end
      default: begin
        div_n     = {ent.total, 16'b0};
        div_d     = {1'b0, ent.count};
        div_steps = tstat_pkg::MEAN_STEPS;
      end
    endcase
  end

  tstat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .steps    (div_steps),
    .quotient (quo),
    .remainder(rem),
    .done     (div_done)
  );

  // The integer part of the mean is held below 2^40.
  assign mean = (quo[71:56] != '0) ? {40'hFF_FFFF_FFFF, quo[15:0]} : quo[55:0];
  assign xf   = {16'b0, x, 16'b0};
  assign t1   = ent.variance - quo[63:0] - {63'b0, (rem != '0)};
  assign vsum = {1'b0, t1} + {1'b0, t2};

  // d = a * 2^16 + b; the square is built from three partial products.
  assign mul_a  = (cmd.sq_phase == tstat_pkg::SQ_P2) ? {8'b0, d[15:0]} : d[39:16];
  assign mul_b  = (cmd.sq_phase == tstat_pkg::SQ_P0) ? d[39:16] : {8'b0, d[15:0]};
  always_comb begin
    case (cmd.sq_phase)
      tstat_pkg::SQ_P2: sq_sum = {1'b0, sq} + {16'b0, prod, 1'b0};
      default:          sq_sum = {1'b0, sq} + {33'b0, prod[47:16]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      idx <= IW'(in_index);
      x   <= in_sample & XMASK;
    end else if (cmd.reduce_step) begin
      idx <= idx - NT;
    end
    if (cmd.load_entry) begin
      ent  <= rdata;
      vnew <= '0;
    end
    if (cmd.div_start) begin
      sel_q <= cmd.div_sel;
    end
    if (div_done) begin
      case (sel_q)
        tstat_pkg::DIV_MEAN: d <= (xf >= mean) ? (xf - mean) : (mean - xf);
        tstat_pkg::DIV_T2:   t2 <= quo[63:0];
        default:             vnew <= vsum[64] ? '1 : vsum[63:0];
      endcase
    end
    if (cmd.sq_step) begin
      prod <= mul_a * mul_b;
      case (cmd.sq_phase)
        tstat_pkg::SQ_P0: big <= (d[55:40] != '0);
        tstat_pkg::SQ_P1: sq  <= {prod, 16'b0};
        tstat_pkg::SQ_P2: sq  <= sq_sum[64] ? '1 : sq_sum[63:0];
        default:          sq  <= (big || sq_sum[64]) ? '1 : sq_sum[63:0];
      endcase
    end
  end

  assign tsum = {1'b0, ent.total} + {33'b0, x};

  always_comb begin
    new_ent.count    = (ent.count == '1) ? ent.count : ent.count + 1'b1;
    new_ent.total    = tsum[56] ? '1 : tsum[55:0];
    new_ent.minimum  = (x < ent.minimum) ? x : ent.minimum;
    new_ent.maximum  = (x > ent.maximum) ? x : ent.maximum;
    new_ent.variance = vnew;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_entry) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      out_entry <= new_ent;
      out_index <= idx[tstat_pkg::INDEX_W-1:0];
    end
  end

  assign status.clear_last = (clr_addr == AW'(NUM_TIMERS - 1));
  assign status.idx_high   = (idx >= NT);
  assign status.count_zero = (rdata.count == '0);
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- hdl/tstat_ctrl.sv -----
// ----------------------------------------------------------------------------
// tstat_ctrl
// Controller: sequences clearing, lookup, divisions, squaring and write back.
// ----------------------------------------------------------------------------
`default_nettype none

module tstat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tstat_pkg::status_t status,
  output tstat_pkg::cmd_t    cmd
);

  typedef enum logic [16:0] {
    S_CLEAR   = 17'b00000000000000001,
    S_IDLE    = 17'b00000000000000010,
    S_REDUCE  = 17'b00000000000000100,
    S_READ    = 17'b00000000000001000,
    S_LOAD    = 17'b00000000000010000,
    S_MEAN_GO = 17'b00000000000100000,
    S_MEAN_WT = 17'b00000000001000000,
    S_SQ0     = 17'b00000000010000000,
    S_SQ1     = 17'b00000000100000000,
    S_SQ2     = 17'b00000001000000000,
    S_SQ3     = 17'b00000010000000000,
    S_T2_GO   = 17'b00000100000000000,
    S_T2_WT   = 17'b00001000000000000,
    S_VAR_GO  = 17'b00010000000000000,
    S_VAR_WT  = 17'b00100000000000000,
    S_WRITE   = 17'b01000000000000000,
    S_SPARE   = 17'b10000000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel  = tstat_pkg::DIV_MEAN;
    cmd.sq_phase = tstat_pkg::SQ_P0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (status.idx_high) cmd.reduce_step = 1'b1;
        else state_next = S_READ;
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_entry = 1'b1;
        state_next = status.count_zero ? S_WRITE : S_MEAN_GO;
      end
      S_MEAN_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_MEAN_WT;
      end
      S_MEAN_WT: begin
        if (status.div_done) state_next = S_SQ0;
      end
      S_SQ0: begin
        cmd.sq_step = 1'b1;
        state_next  = S_SQ1;
      end
      S_SQ1: begin
        cmd.sq_step  = 1'b1;
        cmd.sq_phase = tstat_pkg::SQ_P1;
        state_next   = S_SQ2;
      end
      S_SQ2: begin
        cmd.sq_step  = 1'b1;
        cmd.sq_phase = tstat_pkg::SQ_P2;
        state_next   = S_SQ3;
      end
      S_SQ3: begin
        cmd.sq_step  = 1'b1;
        cmd.sq_phase = tstat_pkg::SQ_P3;
        state_next   = S_T2_GO;
      end
      S_T2_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tstat_pkg::DIV_T2;
        state_next    = S_T2_WT;
      end
      S_T2_WT: begin
        if (status.div_done) state_next = S_VAR_GO;
      end
      S_VAR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tstat_pkg::DIV_VAR;
        state_next    = S_VAR_WT;
      end
      S_VAR_WT: begin
        if (status.div_done) state_next = S_WRITE;
      end
      S_WRITE: begin
        if (status.out_free) begin
          cmd.write_entry = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/tstat_checker.sv -----
// ----------------------------------------------------------------------------
// tstat_checker
// Port-level checks of the timer statistics table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tstat_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] sample_count,
  input logic [55:0] total_ticks,
  input logic [23:0] minimum_ticks,
  input logic [23:0] maximum_ticks,
  input logic [63:0] variance_fixed
);

  // A stalled result keeps its value.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(total_ticks) && $stable(variance_fixed))

  // One sample is in flight at a time.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

  // Every result carries at least one sample, and its range is ordered.
  `ASSERT_IMPLY(a_ordered, clk, rst, out_valid, sample_count != 32'd0 && minimum_ticks <= maximum_ticks && total_ticks >= {32'd0, maximum_ticks})

  // A single sample has no spread.
  `ASSERT_IMPLY(a_first_sample, clk, rst, out_valid && sample_count == 32'd1, variance_fixed == 64'd0 && minimum_ticks == maximum_ticks)

endmodule

bind timer_statistics_table_core tstat_checker u_tstat_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .sample_count  (results.sample_count),
  .total_ticks   (results.total_ticks),
  .minimum_ticks (results.minimum_ticks),
  .maximum_ticks (results.maximum_ticks),
  .variance_fixed(results.variance_fixed)
);

`default_nettype wire

// ----- tb/timer_statistics_table_core_tb.sv -----
// ----------------------------------------------------------------------------
// timer_statistics_table_core_tb
// Self-checking bench: a queue-fed driver sends samples, a monitor compares
// each result transfer with a predicted copy of the table's statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_statistics_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMERS = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [tstat_pkg::INDEX_W-1:0]  timer_index;
    logic [tstat_pkg::SAMPLE_W-1:0] sample_ticks;
  } sample_t;

  typedef struct packed {
    logic [tstat_pkg::INDEX_W-1:0]  entry_index;
    logic [tstat_pkg::COUNT_W-1:0]  sample_count;
    logic [tstat_pkg::TOTAL_W-1:0]  total_ticks;
    logic [tstat_pkg::SAMPLE_W-1:0] minimum_ticks;
    logic [tstat_pkg::SAMPLE_W-1:0] maximum_ticks;
    logic [tstat_pkg::VAR_W-1:0]    variance_fixed;
  } stats_t;

  logic clk;
  logic rst;
  tstat_in_if  samples();
  tstat_out_if results();

  timer_statistics_table_core #(
    .NUM_TIMERS(TIMERS), .SAMPLE_BITS(tstat_pkg::SAMPLE_W)) dut (
    .clk(clk), .rst(rst), .samples(samples.sink), .results(results.source));

  // Predicted copy of the table, one row per timer entry.
  logic [tstat_pkg::COUNT_W-1:0]  shadow_count [TIMERS];
  logic [tstat_pkg::TOTAL_W-1:0]  shadow_total [TIMERS];
  logic [tstat_pkg::SAMPLE_W-1:0] shadow_min   [TIMERS];
  logic [tstat_pkg::SAMPLE_W-1:0] shadow_max   [TIMERS];
  logic [tstat_pkg::VAR_W-1:0]    shadow_var   [TIMERS];

  sample_t pending_samples[$];
  stats_t  expected_stats[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  quiet_phase = 0;   // No random idling on either side while set.
  bit  hold_sender = 0;   // Sender paused while set.
  bit  stim_done = 0;
  bit  in_accepted = 0;   // A sample transfer happened at the last rising edge.

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Squares a fixed-point difference and drops 16 fraction bits,
  // saturating at the full 64-bit range.
  function automatic logic [63:0] square_fixed(input logic [63:0] d);
    logic [127:0] p;
    begin
      p = d * d;
      p = p >> 16;
      square_fixed = (p[127:64] != 0) ? '1 : p[63:0];
    end
  endfunction

  // Applies one sample to the shadow table and returns the new statistics.
  function automatic stats_t update_timer_stats(input sample_t s);
    int unsigned idx;
    logic [63:0] m, n, tot, q, r, mean, xf, d, t1, t2, v, x;
    logic [64:0] sum;
    stats_t res;
    begin
      idx = s.timer_index % TIMERS;
      x = s.sample_ticks;
      v = 0;
      if (shadow_count[idx] != 0) begin
        m = shadow_count[idx];
        n = m + 1;
        tot = shadow_total[idx];
        q = tot / m;
        r = tot % m;
        if (q > 64'hFF_FFFF_FFFF) q = 64'hFF_FFFF_FFFF;
        mean = (q << 16) + ((r << 16) / m);
        xf = x << 16;
        d = (xf >= mean) ? xf - mean : mean - xf;
        t2 = square_fixed(d) / n;
        t1 = shadow_var[idx] - (shadow_var[idx] / m + ((shadow_var[idx] % m) != 0));
        sum = {1'b0, t1} + {1'b0, t2};
        v = sum[64] ? '1 : sum[63:0];
      end
      shadow_var[idx] = v;
      if (x[23:0] < shadow_min[idx]) shadow_min[idx] = x[23:0];
      if (x[23:0] > shadow_max[idx]) shadow_max[idx] = x[23:0];
      sum = {9'd0, shadow_total[idx]} + x;
      shadow_total[idx] = (sum > {9'd0, {tstat_pkg::TOTAL_W{1'b1}}}) ? '1 :
                          sum[tstat_pkg::TOTAL_W-1:0];
      if (shadow_count[idx] != '1) shadow_count[idx] = shadow_count[idx] + 1;
      res.entry_index    = idx[tstat_pkg::INDEX_W-1:0];
      res.sample_count   = shadow_count[idx];
      res.total_ticks    = shadow_total[idx];
      res.minimum_ticks  = shadow_min[idx];
      res.maximum_ticks  = shadow_max[idx];
      res.variance_fixed = shadow_var[idx];
      update_timer_stats = res;
    end
  endfunction

  // Driver: presents the head of the queue and changes on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      samples.valid <= 0;
    end else if (samples.valid && !in_accepted) begin
      // Offer stands until the transfer happens.
    end else if (pending_samples.size() != 0 && !hold_sender &&
                 (quiet_phase || $urandom_range(99) >= 30)) begin
      samples.valid        <= 1;
      samples.timer_index  <= pending_samples[0].timer_index;
      samples.sample_ticks <= pending_samples[0].sample_ticks;
    end else begin
      samples.valid <= 0;
    end
  end

  // Receiver readiness with random stalls.
  always @(negedge clk) begin
    results.ready <= rst ? 1'b0 : (quiet_phase || $urandom_range(99) >= 30);
  end

  // At each transfer on the sample side the prediction is made, so the
  // expectation queue follows the order in which the block accepts items.
  always @(posedge clk) begin
    in_accepted <= !rst && samples.valid && samples.ready;
    if (!rst && samples.valid && samples.ready) begin
      expected_stats = {expected_stats, update_timer_stats(pending_samples.pop_front())};
    end
  end

  // Monitor: compares every result transfer with the oldest expectation.
  always @(posedge clk) begin
    stats_t got, want;
    if (!rst && results.valid && results.ready) begin
      got = '{results.entry_index, results.sample_count, results.total_ticks,
              results.minimum_ticks, results.maximum_ticks, results.variance_fixed};
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = expected_stats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch:");
            $display("  expected idx=%0d cnt=%0d tot=%0d min=%0d max=%0d var=%0d",
                     want.entry_index, want.sample_count, want.total_ticks,
                     want.minimum_ticks, want.maximum_ticks, want.variance_fixed);
            $display("  actual   idx=%0d cnt=%0d tot=%0d min=%0d max=%0d var=%0d",
                     got.entry_index, got.sample_count, got.total_ticks,
                     got.minimum_ticks, got.maximum_ticks, got.variance_fixed);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_stats.size());
      $display("** timer_statistics_table_core: FAILED **");
      $finish;
    end
  end

  task automatic queue_sample(input int unsigned idx, input int unsigned ticks);
    sample_t s;
    s.timer_index  = idx[tstat_pkg::INDEX_W-1:0];
    s.sample_ticks = ticks[tstat_pkg::SAMPLE_W-1:0];
    pending_samples = {pending_samples, s};
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_stats.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned hot_entry, base, spread;
    for (int i = 0; i < TIMERS; i++) begin
      shadow_count[i] = '0;
      shadow_total[i] = '0;
      shadow_min[i]   = '1;
      shadow_max[i]   = '0;
      shadow_var[i]   = '0;
    end
    rst = 1;
    samples.valid = 0;
    samples.timer_index = '0;
    samples.sample_ticks = '0;
    results.ready = 0;
    repeat (11) @(posedge clk);
    rst <= 0;

    // Directed part: index and sample extremes, first sample of an entry,
    // a repeated sample (zero difference), and large swings that stress
    // the square and its saturation.
    queue_sample(0, 0);
    queue_sample(63, 24'hFFFFFF);
    queue_sample(63, 0);
    queue_sample(63, 24'hFFFFFF);
    queue_sample(63, 24'hFFFFFF);
    queue_sample(0, 0);
    queue_sample(0, 24'hFFFFFF);
    queue_sample(5, 1000);
    queue_sample(5, 1000);
    queue_sample(5, 1000);
    queue_sample(5, 1001);
    queue_sample(42, 24'h555555);
    queue_sample(42, 24'hAAAAAA);
    queue_sample(21, 24'hAAAAAA);
    queue_sample(21, 24'h555555);
    queue_sample(1, 1);
    queue_sample(1, 24'hFFFFFE);
    queue_sample(1, 2);

    // Pressure: once every result is back, hold the sender with a sample queued.
    wait_drained();
    hold_sender = 1;
    queue_sample(5, 7);
    repeat (50) @(posedge clk);
    hold_sender = 0;

    // Random part: most samples hit a few busy entries with clustered
    // values so the variance grows over long histories; the rest is noise.
    for (int i = 0; i < 780; i++) begin
      if (i == 300) begin
        wait_drained();
        quiet_phase = 1;
      end
      if (i == 420) begin
        wait_drained();
        quiet_phase = 0;
      end
      if ($urandom_range(99) < 70) begin
        hot_entry = $urandom_range(3);
        base   = (hot_entry + 1) * 24'h030000;
        spread = 1 << $urandom_range(20);
        queue_sample(hot_entry * 17, base + $urandom_range(spread));
      end else begin
        queue_sample($urandom_range(63), $urandom());
      end
    end

    wait_drained();
    repeat (500) @(posedge clk);
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("** timer_statistics_table_core: PASSED **");
    end else begin
      $display("** timer_statistics_table_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/tstat_pkg.sv
hdl/tstat_in_if.sv
hdl/tstat_out_if.sv
hdl/tstat_ram.sv
hdl/tstat_div.sv
hdl/tstat_dp.sv
hdl/tstat_ctrl.sv
hdl/timer_statistics_table_core.sv
hdl/tstat_checker.sv
tb/timer_statistics_table_core_tb.sv
